// ----- hdl/oeg_pkg.sv -----
// Shared definitions for the orthogonality energy and gradient pipeline.
// Holds the pipeline depth and the control bundle passed from the stage controller.
// No dependencies.
package oeg_pkg;

    // Number of register stages, the output register included.
    localparam int NUM_STAGES = 7;

    // Per-stage handshake state handed from the controller to the datapath.
    typedef struct packed {
        logic                  in_ready;
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// ----- hdl/orthogonality_energy_gradient_unit.sv -----
// A beat accepted on the s_ side passes stages 1 to 7 in order, the output register last, then appears on the m_ side.
// Throughput: one body per cycle while m_ready is high, set by the seven-stage multiply and reduce pipeline.
// Back pressure collapses bubbles; any free stage lets a new beat in.
// Reset (synchronous, active low) empties all stages and loads stiffness 1.0 and 3D.
// Depends on oeg_pkg and oeg_pipe_ctrl.
module orthogonality_energy_gradient_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration write port.
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_a_c0_r0,
    input  logic signed [31:0] s_a_c0_r1,
    input  logic signed [31:0] s_a_c0_r2,
    input  logic signed [31:0] s_a_c1_r0,
    input  logic signed [31:0] s_a_c1_r1,
    input  logic signed [31:0] s_a_c1_r2,
    input  logic signed [31:0] s_a_c2_r0,
    input  logic signed [31:0] s_a_c2_r1,
    input  logic signed [31:0] s_a_c2_r2,
    input  logic [31:0]        s_body_volume,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [62:0]        m_energy,
    output logic signed [47:0] m_g_c0_r0,
    output logic signed [47:0] m_g_c0_r1,
    output logic signed [47:0] m_g_c0_r2,
    output logic signed [47:0] m_g_c1_r0,
    output logic signed [47:0] m_g_c1_r1,
    output logic signed [47:0] m_g_c1_r2,
    output logic signed [47:0] m_g_c2_r0,
    output logic signed [47:0] m_g_c2_r1,
    output logic signed [47:0] m_g_c2_r2,
    output logic               m_saturated
);

    // Register map and reset values.
    localparam logic [1:0]  REG_STIFFNESS   = 2'd0;
    localparam logic [1:0]  REG_SPACE_DIM   = 2'd1;
    localparam logic [31:0] STIFFNESS_RESET = 32'h0001_0000;
    localparam logic [1:0]  DIM_RESET       = 2'd3;
    localparam logic [1:0]  DIM_2D          = 2'd2;

    // Field widths and fixed-point positions.
    localparam int A_W     = 32;
    localparam int E_W     = 63;
    localparam int G_W     = 48;
    localparam int FRAC_A  = 28;
    localparam int AA_W    = 64;            // A*A product
    localparam int MS_W    = 66;            // sum of three A*A products
    localparam int M_W     = MS_W - FRAC_A; // M = A*A^T - I, Q.28
    localparam int SQ_W    = 75;            // M squared, unsigned
    localparam int RS_W    = 77;            // row sum of squares
    localparam int SS_W    = 79;            // full sum of squares
    localparam int S_FRAC  = 24;
    localparam int S_W     = SS_W - S_FRAC; // S, unsigned Q.32
    localparam int MA_W    = M_W + A_W;     // M*A product
    localparam int PS_W    = MA_W + 2;      // sum of three M*A products
    localparam int P_W     = PS_W - FRAC_A; // P = M*A, Q.28
    localparam int KV_W    = 64;
    localparam int GPH_W   = 45;            // signed partial of kV by the top of P
    localparam int GM_W    = 66;            // middle partial sum of the gradient
    localparam int GS_W    = 110;           // full gradient product
    localparam int G_SHIFT = 34;
    localparam int EPH_W   = 55;            // partial of kV by the top of S
    localparam int EM_W    = 65;            // middle partial sum of the energy
    localparam int ES_W    = 120;           // full energy product
    localparam int E_SHIFT = 32;
    localparam int GHI_W   = GS_W - (G_SHIFT + G_W - 1);

    localparam logic signed [MS_W-1:0] M_HALF = MS_W'(1) <<< (FRAC_A - 1);
    localparam logic [M_W-1:0]         M_ONE  = M_W'(1) << FRAC_A;
    localparam logic signed [PS_W-1:0] P_HALF = PS_W'(1) <<< (FRAC_A - 1);
    localparam logic [SS_W-1:0]        S_HALF = SS_W'(1) << (S_FRAC - 1);
    localparam logic [GS_W-1:0]        G_HALF = GS_W'(1) << (G_SHIFT - 1);
    localparam logic [ES_W-1:0]        E_HALF = ES_W'(1) << (E_SHIFT - 1);
    localparam logic [E_W-1:0]         E_MAX  = {E_W{1'b1}};
    localparam logic [G_W-1:0]         G_MAX  = {1'b0, {(G_W-1){1'b1}}};
    localparam logic [G_W-1:0]         G_MIN  = {1'b1, {(G_W-1){1'b0}}};

    oeg_pkg::pipe_ctrl_t pipe;

    logic [31:0] stiffness_reg;
    logic [1:0]  space_dim_reg;
    logic        dim2;

    // Stage 1: masked matrix, A*A products, k*V.
    logic signed [A_W-1:0]  a_in [3][3];
    logic signed [A_W-1:0]  a_msk [3][3];
    logic signed [AA_W-1:0] aa_next [3][3][3];
    logic [KV_W-1:0]        kv_next;
    logic signed [A_W-1:0]  st1_a_reg [3][3];
    logic signed [AA_W-1:0] st1_aa_reg [3][3][3];
    logic [KV_W-1:0]        st1_kv_reg;

    // Stage 2: M.
    logic signed [M_W-1:0]  m_next [3][3];
    logic signed [M_W-1:0]  st2_m_reg [3][3];
    logic signed [A_W-1:0]  st2_a_reg [3][3];
    logic [KV_W-1:0]        st2_kv_reg;

    // Stage 3: squares of M and M*A products.
    logic [SQ_W-1:0]        sq_next [3][3];
    logic signed [MA_W-1:0] ma_next [3][3][3];
    logic [SQ_W-1:0]        st3_sq_reg [3][3];
    logic signed [MA_W-1:0] st3_ma_reg [3][3][3];
    logic [KV_W-1:0]        st3_kv_reg;

    // Stage 4: row sums of squares and P.
    logic [RS_W-1:0]        rsq_next [3];
    logic signed [P_W-1:0]  p_next [3][3];
    logic [RS_W-1:0]        st4_rsq_reg [3];
    logic signed [P_W-1:0]  st4_p_reg [3][3];
    logic [KV_W-1:0]        st4_kv_reg;

    // Stage 5: S and gradient partial products.
    logic [S_W-1:0]          s_next;
    logic [63:0]             gll_next [3][3];
    logic [63:0]             ghl_next [3][3];
    logic signed [GPH_W-1:0] glh_next [3][3];
    logic signed [GPH_W-1:0] ghh_next [3][3];
    logic [S_W-1:0]          st5_s_reg;
    logic [63:0]             st5_gll_reg [3][3];
    logic [63:0]             st5_ghl_reg [3][3];
    logic signed [GPH_W-1:0] st5_glh_reg [3][3];
    logic signed [GPH_W-1:0] st5_ghh_reg [3][3];
    logic [KV_W-1:0]         st5_kv_reg;

    // Stage 6: energy partial products and gradient sums.
    logic [63:0]      ell_next;
    logic [EPH_W-1:0] elh_next;
    logic [63:0]      ehl_next;
    logic [EPH_W-1:0] ehh_next;
    logic [GS_W-1:0]  gs_next [3][3];
    logic [63:0]      st6_ell_reg;
    logic [EPH_W-1:0] st6_elh_reg;
    logic [63:0]      st6_ehl_reg;
    logic [EPH_W-1:0] st6_ehh_reg;
    logic [GS_W-1:0]  st6_gs_reg [3][3];

    // Stage 7: output register.
    logic [E_W-1:0]        energy_next;
    logic signed [G_W-1:0] g_next [3][3];
    logic                  sat_next;
    logic [E_W-1:0]        out_energy_reg;
    logic signed [G_W-1:0] out_g_reg [3][3];
    logic                  out_sat_reg;

    oeg_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .ctrl    (pipe)
    );

    assign s_ready = pipe.in_ready;
    assign m_valid = pipe.valid[oeg_pkg::NUM_STAGES-1];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg <= STIFFNESS_RESET;
            space_dim_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_STIFFNESS: stiffness_reg <= cfg_wr_data;
                REG_SPACE_DIM: space_dim_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    assign dim2 = (space_dim_reg == DIM_2D);

    // Input matrix, indexed by row then column.
    assign a_in[0][0] = s_a_c0_r0;
    assign a_in[1][0] = s_a_c0_r1;
    assign a_in[2][0] = s_a_c0_r2;
    assign a_in[0][1] = s_a_c1_r0;
    assign a_in[1][1] = s_a_c1_r1;
    assign a_in[2][1] = s_a_c1_r2;
    assign a_in[0][2] = s_a_c2_r0;
    assign a_in[1][2] = s_a_c2_r1;
    assign a_in[2][2] = s_a_c2_r2;

    // Stage 1 logic: clear row and column 2 in 2D, then form A*A products.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                a_msk[r][c] = (dim2 && (r == 2 || c == 2)) ? '0 : a_in[r][c];
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    aa_next[i][j][k] = a_msk[i][k] * a_msk[j][k];
                end
            end
        end
        kv_next = stiffness_reg * s_body_volume;
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[0]) begin
            st1_a_reg  <= a_msk;
            st1_aa_reg <= aa_next;
            st1_kv_reg <= kv_next;
        end
    end

    // Stage 2 logic: round the Gram entries to Q.28 and take off the identity.
    always_comb begin
        logic signed [MS_W-1:0] msum;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                msum = MS_W'(st1_aa_reg[i][j][0]) + MS_W'(st1_aa_reg[i][j][1])
                     + MS_W'(st1_aa_reg[i][j][2]) + M_HALF;
                m_next[i][j] = msum[MS_W-1:FRAC_A]
                             - ((i == j && (i < 2 || !dim2)) ? M_ONE : '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[1]) begin
            st2_m_reg  <= m_next;
            st2_a_reg  <= st1_a_reg;
            st2_kv_reg <= st1_kv_reg;
        end
    end

    // Stage 3 logic: squares of M for the energy and M*A products for the gradient.
    always_comb begin
        logic signed [2*M_W-1:0] sq_full;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sq_full = st2_m_reg[i][j] * st2_m_reg[i][j];
                sq_next[i][j] = sq_full[SQ_W-1:0];
                for (int k = 0; k < 3; k++) begin
                    ma_next[i][j][k] = st2_m_reg[i][k] * st2_a_reg[k][j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[2]) begin
            st3_sq_reg <= sq_next;
            st3_ma_reg <= ma_next;
            st3_kv_reg <= st2_kv_reg;
        end
    end

    // Stage 4 logic: row sums of the squares and P rounded to Q.28.
    always_comb begin
        logic signed [PS_W-1:0] psum;
        for (int i = 0; i < 3; i++) begin
            rsq_next[i] = RS_W'(st3_sq_reg[i][0]) + RS_W'(st3_sq_reg[i][1])
                        + RS_W'(st3_sq_reg[i][2]);
            for (int j = 0; j < 3; j++) begin
                psum = PS_W'(st3_ma_reg[i][j][0]) + PS_W'(st3_ma_reg[i][j][1])
                     + PS_W'(st3_ma_reg[i][j][2]) + P_HALF;
                p_next[i][j] = psum[PS_W-1:FRAC_A];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[3]) begin
            st4_rsq_reg <= rsq_next;
            st4_p_reg   <= p_next;
            st4_kv_reg  <= st3_kv_reg;
        end
    end

    // Stage 5 logic: S rounded to Q.32, and kV times P split into 32-bit halves.
    always_comb begin
        logic [SS_W-1:0] ssum;
        logic [31:0]     kl;
        logic [31:0]     kh;
        kl = st4_kv_reg[31:0];
        kh = st4_kv_reg[KV_W-1:32];
        ssum = SS_W'(st4_rsq_reg[0]) + SS_W'(st4_rsq_reg[1]) + SS_W'(st4_rsq_reg[2]) + S_HALF;
        s_next = ssum[SS_W-1:S_FRAC];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                gll_next[i][j] = kl * st4_p_reg[i][j][31:0];
                ghl_next[i][j] = kh * st4_p_reg[i][j][31:0];
                glh_next[i][j] = $signed({1'b0, kl}) * $signed(st4_p_reg[i][j][P_W-1:32]);
                ghh_next[i][j] = $signed({1'b0, kh}) * $signed(st4_p_reg[i][j][P_W-1:32]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[4]) begin
            st5_s_reg   <= s_next;
            st5_gll_reg <= gll_next;
            st5_ghl_reg <= ghl_next;
            st5_glh_reg <= glh_next;
            st5_ghh_reg <= ghh_next;
            st5_kv_reg  <= st4_kv_reg;
        end
    end

    // Stage 6 logic: kV times S partial products, and the gradient partials summed
    // with the rounding constant.
    always_comb begin
        logic [31:0]     kl;
        logic [31:0]     kh;
        logic [GM_W-1:0] g_mid;
        kl = st5_kv_reg[31:0];
        kh = st5_kv_reg[KV_W-1:32];
        ell_next = kl * st5_s_reg[31:0];
        elh_next = kl * st5_s_reg[S_W-1:32];
        ehl_next = kh * st5_s_reg[31:0];
        ehh_next = kh * st5_s_reg[S_W-1:32];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                g_mid = {2'b00, st5_ghl_reg[i][j]}
                      + {{(GM_W-GPH_W){st5_glh_reg[i][j][GPH_W-1]}}, st5_glh_reg[i][j]};
                gs_next[i][j] = {st5_ghh_reg[i][j][GPH_W-1], st5_ghh_reg[i][j], 64'd0}
                              + {{(GS_W-GM_W-32){g_mid[GM_W-1]}}, g_mid, 32'd0}
                              + {{(GS_W-64){1'b0}}, st5_gll_reg[i][j]}
                              + G_HALF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[5]) begin
            st6_ell_reg <= ell_next;
            st6_elh_reg <= elh_next;
            st6_ehl_reg <= ehl_next;
            st6_ehh_reg <= ehh_next;
            st6_gs_reg  <= gs_next;
        end
    end

    // Stage 7 logic: finish the energy product, shift both results and saturate.
    always_comb begin
        logic [EM_W-1:0]  e_mid;
        logic [ES_W-1:0]  e_sum;
        logic             e_sat;
        logic [GHI_W-1:0] g_hi;
        logic             g_fit;
        logic             g_sat_any;
        e_mid = EM_W'(st6_elh_reg) + EM_W'(st6_ehl_reg);
        e_sum = {1'b0, st6_ehh_reg, 64'd0}
              + {{(ES_W-EM_W-32){1'b0}}, e_mid, 32'd0}
              + {{(ES_W-64){1'b0}}, st6_ell_reg}
              + E_HALF;
        e_sat = |e_sum[ES_W-1:E_SHIFT+E_W];
        energy_next = e_sat ? E_MAX : e_sum[E_SHIFT+E_W-1:E_SHIFT];
        g_sat_any = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                g_hi  = st6_gs_reg[i][j][GS_W-1:G_SHIFT+G_W-1];
                g_fit = (&g_hi) || !(|g_hi);
                if (g_fit) begin
                    g_next[i][j] = st6_gs_reg[i][j][G_SHIFT+G_W-1:G_SHIFT];
                end else begin
                    g_next[i][j] = st6_gs_reg[i][j][GS_W-1] ? G_MIN : G_MAX;
                end
                g_sat_any = g_sat_any || !g_fit;
            end
        end
        sat_next = e_sat || g_sat_any;
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[6]) begin
            out_energy_reg <= energy_next;
            out_g_reg      <= g_next;
            out_sat_reg    <= sat_next;
        end
    end

    assign m_energy    = out_energy_reg;
    assign m_g_c0_r0   = out_g_reg[0][0];
    assign m_g_c0_r1   = out_g_reg[1][0];
    assign m_g_c0_r2   = out_g_reg[2][0];
    assign m_g_c1_r0   = out_g_reg[0][1];
    assign m_g_c1_r1   = out_g_reg[1][1];
    assign m_g_c1_r2   = out_g_reg[2][1];
    assign m_g_c2_r0   = out_g_reg[0][2];
    assign m_g_c2_r1   = out_g_reg[1][2];
    assign m_g_c2_r2   = out_g_reg[2][2];
    assign m_saturated = out_sat_reg;

`ifndef NO_ASSERTIONS
    // In 2D the third row and column of the gradient come out as zero.
    a_2d_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && space_dim_reg == DIM_2D) |->
            (m_g_c0_r2 == '0 && m_g_c1_r2 == '0 && m_g_c2_r0 == '0
             && m_g_c2_r1 == '0 && m_g_c2_r2 == '0))
        else $error("nonzero gradient outside the 2D block");

    // A saturated beat carries at least one result pinned at a limit.
    a_sat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_energy == E_MAX
             || m_g_c0_r0 == G_MAX || m_g_c0_r0 == G_MIN
             || m_g_c0_r1 == G_MAX || m_g_c0_r1 == G_MIN
             || m_g_c0_r2 == G_MAX || m_g_c0_r2 == G_MIN
             || m_g_c1_r0 == G_MAX || m_g_c1_r0 == G_MIN
             || m_g_c1_r1 == G_MAX || m_g_c1_r1 == G_MIN
             || m_g_c1_r2 == G_MAX || m_g_c1_r2 == G_MIN
             || m_g_c2_r0 == G_MAX || m_g_c2_r0 == G_MIN
             || m_g_c2_r1 == G_MAX || m_g_c2_r1 == G_MIN
             || m_g_c2_r2 == G_MAX || m_g_c2_r2 == G_MIN))
        else $error("saturation flagged with no result at a limit");
`endif

endmodule

// ----- hdl/oeg_pipe_ctrl.sv -----
// Valid/ready controller for the orthogonality energy pipeline.
// Tracks one valid bit per stage and lets bubbles collapse under back pressure.
// Depends on oeg_pkg.
module oeg_pipe_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               m_ready,
    output oeg_pkg::pipe_ctrl_t ctrl
);

    localparam int LAST = oeg_pkg::NUM_STAGES - 1;

    logic [oeg_pkg::NUM_STAGES-1:0] vld_reg;
    logic [oeg_pkg::NUM_STAGES-1:0] vld_next;
    logic [oeg_pkg::NUM_STAGES-1:0] load;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        load[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            load[k] = !vld_reg[k] || load[k+1];
        end
        vld_next[0] = load[0] ? s_valid : vld_reg[0];
        for (int k = 1; k <= LAST; k++) begin
            vld_next[k] = load[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.in_ready = load[0];
    assign ctrl.load     = load;
    assign ctrl.valid    = vld_reg;

`ifndef NO_ASSERTIONS
    // Occupancy changes only by accepted input beats and delivered output beats.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(vld_reg) == $past($countones(vld_reg))
                + int'($past(s_valid && load[0]))
                - int'($past(vld_reg[LAST] && m_ready))))
        else $error("pipeline occupancy lost or duplicated a beat");

    // Input is refused only when every stage is full and the output is stalled.
    a_refuse_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !load[0] |-> ((&vld_reg) && !m_ready))
        else $error("input stalled while the pipeline had a free stage");
`endif

endmodule
